// ===== sv/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debounce / long press block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

	localparam int unsigned LinesDefault    = 16;
	localparam int unsigned TickBitsDefault = 16;

	localparam int unsigned LineW = 4;
	localparam int unsigned PinW  = 16;
	localparam int unsigned RegW  = 16;
	localparam int unsigned IdxW  = 2;

	localparam int unsigned InDataW  = 24;
	localparam int unsigned OutDataW = 8;

	localparam logic [RegW-1:0] DebounceReset  = 16'd50;
	localparam logic [RegW-1:0] LongPressReset = 16'd1000;
	localparam logic [RegW-1:0] EnableReset    = 16'hFFFF;

	typedef enum logic [IdxW-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_LINE_EN    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [PinW-1:0]  pressed_lines;
		logic [LineW-1:0] edge_line;
		logic             edge_valid;
	} item_t;

	typedef struct packed {
		logic             long_press;
		logic [LineW-1:0] key_line;
	} result_t;

	typedef struct packed {
		logic            we;
		reg_idx_t        index;
		logic [RegW-1:0] data;
	} cfg_wr_t;

endpackage

`default_nettype wire

// ===== sv/button_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounces a bank of edge-interrupt buttons and reports short / long presses.
// ----------------------------------------------------------------------------
// Each slave beat is one timer tick. The block takes one tick per clock cycle;
// a tick reaches the input register at the edge it is accepted, is evaluated
// against the debounce state in the following cycle, and its key report (if
// any) is loaded into the result register when the core takes the tick.
// Only a pending report that the master side refuses holds up further ticks.
// Configuration writes go through cfg_we / cfg_index / cfg_data and should
// be made while no tick is in flight.
`default_nettype none

module button_debounce_long_press #(
	parameter int unsigned LINES     = bdlp_pkg::LinesDefault,
	parameter int unsigned TICK_BITS = bdlp_pkg::TickBitsDefault
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [bdlp_pkg::IdxW-1:0]        cfg_index,
	input  wire  [bdlp_pkg::RegW-1:0]        cfg_data,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// [0] edge_valid, [4:1] edge_line, [20:5] pressed_lines, [23:21] zero
	input  wire  [bdlp_pkg::InDataW-1:0]     s_tdata,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// [3:0] key_line, [4] long_press, [7:5] zero
	output logic [bdlp_pkg::OutDataW-1:0]    m_tdata
);

	bdlp_pkg::cfg_wr_t cfg;
	bdlp_pkg::item_t   in_item, item_s1;
	bdlp_pkg::result_t res, out_res;
	logic              valid_s1, take_s1, res_valid, out_free;

	assign cfg.we    = cfg_we;
	assign cfg.index = bdlp_pkg::reg_idx_t'(cfg_index);
	assign cfg.data  = cfg_data;

	assign in_item = s_tdata[$bits(bdlp_pkg::item_t)-1:0];

	bdlp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.take_s1  (take_s1),
		.item_s1  (item_s1)
	);

	bdlp_core #(
		.LINES     (LINES),
		.TICK_BITS (TICK_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.take_s1   (take_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	bdlp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take_s1 && res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {{(bdlp_pkg::OutDataW - $bits(bdlp_pkg::result_t)){1'b0}}, out_res};

endmodule

`default_nettype wire

// ===== sv/bdlp_in_stage.sv =====
// ----------------------------------------------------------------------------
// bdlp_in_stage
// Input register: holds one tick beat until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_in_stage (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  bdlp_pkg::item_t      in_item,
	output logic                 valid_s1,
	input  wire                  take_s1,
	output bdlp_pkg::item_t      item_s1
);

	logic v_s1;

	assign in_ready = !v_s1 || take_s1;
	assign valid_s1 = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bdlp_core.sv =====
// ----------------------------------------------------------------------------
// bdlp_core
// Configuration registers, debounce state and the per-tick update.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_core #(
	parameter int unsigned LINES     = bdlp_pkg::LinesDefault,
	parameter int unsigned TICK_BITS = bdlp_pkg::TickBitsDefault
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  bdlp_pkg::cfg_wr_t    cfg,
	input  wire                  valid_s1,
	input  bdlp_pkg::item_t      item_s1,
	input  wire                  out_free,
	output logic                 take_s1,
	output logic                 res_valid,
	output bdlp_pkg::result_t    res
);

	localparam int unsigned CmpW = 33;
	localparam logic [TICK_BITS-1:0] TickMax = {TICK_BITS{1'b1}};

	logic [bdlp_pkg::RegW-1:0]  debounce_q, long_press_q, line_en_q;
	logic                       armed_q, btn_valid_q, confirmed_q, long_rep_q;
	logic [bdlp_pkg::LineW-1:0] btn_line_q;
	logic [TICK_BITS-1:0]       elapsed_q;
	logic [LINES-1:0]           unmasked_q;

	logic                       armed_d, btn_valid_d, confirmed_d, long_rep_d;
	logic [bdlp_pkg::LineW-1:0] btn_line_d;
	logic [TICK_BITS-1:0]       elapsed_d;
	logic [LINES-1:0]           unmasked_d;

	logic [LINES-1:0] en_vec, line_sel;
	logic             accepted, held, hit;
	logic [CmpW-1:0]  lat_w, db_w, lp_w;
	logic             long_d;

	for (genvar i = 0; i < LINES; i++) begin : g_line
		if (i < bdlp_pkg::RegW) begin : g_en
			assign en_vec[i] = line_en_q[i];
		end else begin : g_off
			assign en_vec[i] = 1'b0;
		end
		assign line_sel[i] = (32'(item_s1.edge_line) == i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bdlp_pkg::DebounceReset;
			long_press_q <= bdlp_pkg::LongPressReset;
			line_en_q    <= bdlp_pkg::EnableReset;
		end else if (cfg.we) begin
			case (cfg.index)
				bdlp_pkg::REG_DEBOUNCE:   debounce_q   <= cfg.data;
				bdlp_pkg::REG_LONG_PRESS: long_press_q <= cfg.data;
				bdlp_pkg::REG_LINE_EN:    line_en_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		hit          = |(line_sel & en_vec & unmasked_q);
		accepted     = item_s1.edge_valid && hit;
		armed_d      = armed_q;
		btn_valid_d  = btn_valid_q;
		confirmed_d  = confirmed_q;
		long_rep_d   = long_rep_q;
		btn_line_d   = btn_line_q;
		unmasked_d   = unmasked_q;
		res_valid    = 1'b0;
		long_d       = 1'b0;

		if (accepted) begin
			unmasked_d  = unmasked_q & ~line_sel;
			btn_line_d  = item_s1.edge_line;
			btn_valid_d = 1'b1;
			armed_d     = 1'b1;
			elapsed_d   = '0;
		end else if (elapsed_q != TickMax) begin
			elapsed_d = elapsed_q + TICK_BITS'(1);
		end else begin
			elapsed_d = elapsed_q;
		end

		held  = item_s1.pressed_lines[btn_line_d];
		lat_w = CmpW'(elapsed_d);
		db_w  = CmpW'(debounce_q);
		lp_w  = CmpW'(long_press_q);

		if (armed_d) begin
			if (btn_valid_d && !long_rep_d) begin
				if (!confirmed_d && lat_w >= db_w) begin
					if (held) begin
						confirmed_d = 1'b1;
					end else begin
						elapsed_d   = '0;
						btn_valid_d = 1'b0;
					end
				end
				if (confirmed_d) begin
					if (!held) begin
						res_valid   = 1'b1;
						elapsed_d   = '0;
						confirmed_d = 1'b0;
						btn_valid_d = 1'b0;
					end else if (lat_w >= lp_w) begin
						res_valid  = 1'b1;
						long_d     = 1'b1;
						long_rep_d = 1'b1;
					end
				end
			end else if (confirmed_d) begin
				if (!held) begin
					elapsed_d   = '0;
					confirmed_d = 1'b0;
					btn_valid_d = 1'b0;
					long_rep_d  = 1'b0;
				end
			end else if (lat_w > db_w) begin
				armed_d    = 1'b0;
				unmasked_d = unmasked_d | en_vec;
			end
		end
	end

	// a tick with no result never waits on the output side
	assign take_s1        = valid_s1 && (out_free || !res_valid);
	assign res.key_line   = btn_line_d;
	assign res.long_press = long_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			btn_valid_q <= 1'b0;
			confirmed_q <= 1'b0;
			long_rep_q  <= 1'b0;
			btn_line_q  <= '0;
			elapsed_q   <= '0;
			unmasked_q  <= '1;
		end else if (take_s1) begin
			armed_q     <= armed_d;
			btn_valid_q <= btn_valid_d;
			confirmed_q <= confirmed_d;
			long_rep_q  <= long_rep_d;
			btn_line_q  <= btn_line_d;
			elapsed_q   <= elapsed_d;
			unmasked_q  <= unmasked_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bdlp_out_stage.sv =====
// ----------------------------------------------------------------------------
// bdlp_out_stage
// Result register towards the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_out_stage (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  bdlp_pkg::result_t    res,
	output logic                 out_free,
	output logic                 out_valid,
	input  wire                  out_ready,
	output bdlp_pkg::result_t    out_res
);

	logic valid_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			out_res <= res;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bdlp_checker.sv =====
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks for button_debounce_long_press.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          s_tready,
	input wire                          m_tvalid,
	input wire                          m_tready,
	input wire [bdlp_pkg::OutDataW-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled beat changed");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("slave side stalled with master side ready");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:5] == 3'b000)
		else $error("padding bits set");

	a_rst: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("beat offered in reset");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
